/* sv/nfq_pkg.sv */
package nfq_pkg;

  typedef enum logic [1:0] {
    ACT_FP8  = 2'd0,
    ACT_HALF = 2'd1,
    ACT_BF16 = 2'd2,
    ACT_PASS = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] value_bits;
  } in_item_t;

  typedef struct packed {
    logic [15:0] narrow_bits;
    logic [31:0] widened_bits;
  } out_item_t;

  localparam logic [31:0] F32_EXP_MASK = 32'h7F80_0000;
  localparam logic [31:0] F32_QNAN     = 32'h7FC0_0000;
  localparam logic [7:0]  HALF_BIAS_DIFF = 8'd112;

  // Right shift with round to nearest, ties to even; sh below 32.
  function automatic logic [24:0] rne_shr(input logic [23:0] v, input logic [4:0] sh);
    logic [23:0] t;
    logic [23:0] r;
    logic [23:0] h;
    logic [23:0] msk;
    begin
      if (sh == 5'd0) begin
        rne_shr = {1'b0, v};
      end else begin
        t   = v >> sh;
        msk = (24'd1 << sh) - 24'd1;
        r   = v & msk;
        h   = 24'd1 << (sh - 5'd1);
        if (r > h || (r == h && t[0])) rne_shr = {1'b0, t} + 25'd1;
        else rne_shr = {1'b0, t};
      end
    end
  endfunction

  // Highest set bit index of a nonzero 10-bit value.
  function automatic logic [3:0] msb10(input logic [9:0] v);
    logic [3:0] p;
    begin
      p = 4'd0;
      for (int i = 0; i < 10; i++) begin
        if (v[i]) p = 4'(i);
      end
      msb10 = p;
    end
  endfunction

endpackage

/* sv/nfq_stream_if.sv */
interface nfq_stream_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/nfq_fp8_conv.sv */
module nfq_fp8_conv (
  input  logic [31:0] value_i,
  output logic [7:0]  narrow_o,
  output logic [31:0] widened_o
);
  import nfq_pkg::*;

  logic        s;
  logic [7:0]  e;
  logic [22:0] f;
  logic [8:0]  fe;
  logic [24:0] m;
  logic [3:0]  p;
  logic [2:0]  fr;
  logic [3:0]  ex;
  logic [6:0]  mag;
  logic [22:0] frw;

  always_comb begin
    s  = value_i[31];
    e  = value_i[30:23];
    f  = value_i[22:0];
    fe = {1'b0, e} - 9'd120;
    m  = '0;
    mag = 7'h00;
    if (e == 8'hFF) begin
      mag = (f != 0) ? 7'h7F : 7'h7E;
    end else if (value_i[30:0] == 31'd0 || e < 8'd117) begin
      mag = 7'h00;
    end else if (e > 8'd135) begin
      mag = 7'h7E;
    end else if (e <= 8'd120) begin
      m = rne_shr({1'b1, f}, 5'(8'd141 - e));
      mag = (m >= 25'd8) ? 7'h08 : {4'd0, m[2:0]};
    end else begin
      m = rne_shr({1'b0, f}, 5'd20);
      if (m >= 25'd8) begin
        mag = (fe[3:0] == 4'd15) ? 7'h7E : {fe[3:0] + 4'd1, 3'd0};
      end else if (fe[3:0] == 4'd15 && m[2:0] == 3'd7) begin
        mag = 7'h7E;
      end else begin
        mag = {fe[3:0], m[2:0]};
      end
    end
    narrow_o = {s, mag};
    ex = mag[6:3];
    fr = mag[2:0];
    p  = msb10({7'd0, fr});
    frw = {20'd0, fr & ~(3'd1 << p)};
    if (ex == 4'd0) begin
      if (fr == 3'd0) widened_o = {s, 31'd0};
      else widened_o = {s, {4'd0, p} + 8'd118, frw << (5'd23 - {1'b0, p})};
    end else if (ex == 4'hF && fr == 3'd7) begin
      widened_o = {s, F32_QNAN[30:0]};
    end else begin
      widened_o = {s, 8'({4'd0, ex} + 8'd120), fr, 20'd0};
    end
  end
endmodule

/* sv/nfq_half_conv.sv */
module nfq_half_conv (
  input  logic [31:0] value_i,
  output logic [15:0] narrow_o,
  output logic [31:0] widened_o
);
  import nfq_pkg::*;

  logic        s;
  logic [7:0]  e;
  logic [22:0] f;
  logic [7:0]  he;
  logic [24:0] m;
  logic [14:0] mag;
  logic [4:0]  hx;
  logic [9:0]  hf;
  logic [3:0]  p;

  always_comb begin
    s   = value_i[31];
    e   = value_i[30:23];
    f   = value_i[22:0];
    he  = e - HALF_BIAS_DIFF;
    m   = '0;
    if (e == 8'hFF) begin
      mag = (f == 0) ? 15'h7C00 : {5'h1F, (f[22:13] == 0) ? 10'd1 : f[22:13]};
    end else if (e >= 8'd143) begin
      mag = 15'h7C00;
    end else if (e < 8'd102) begin
      mag = 15'd0;
    end else if (e <= 8'd112) begin
      m = rne_shr({1'b1, f}, 5'(8'd126 - e));
      mag = (m >= 25'h400) ? 15'h0400 : {5'd0, m[9:0]};
    end else begin
      m = rne_shr({1'b0, f}, 5'd13);
      if (m >= 25'h400) mag = (he[4:0] == 5'd30) ? 15'h7C00 : {he[4:0] + 5'd1, 10'd0};
      else mag = {he[4:0], m[9:0]};
    end
    narrow_o = {s, mag};
    hx = mag[14:10];
    hf = mag[9:0];
    p  = msb10(hf);
    if (hx == 5'd0) begin
      if (hf == 10'd0) widened_o = {s, 31'd0};
      else widened_o = {s, {4'd0, p} + 8'd103,
                        23'({13'd0, hf & ~(10'd1 << p)} << (5'd23 - 5'(p)))};
    end else if (hx == 5'h1F) begin
      widened_o = {s, 8'hFF, hf, 13'd0};
    end else begin
      widened_o = {s, 8'({3'd0, hx} + HALF_BIAS_DIFF), hf, 13'd0};
    end
  end
endmodule

/* sv/narrow_float_quantizer.sv */
// Registered path: an input register, then a result register, between input transfer and result transfer.
// Throughput: one item per cycle; only a low ready from the receiver stalls it.
// Reset: rst_ni asynchronously clears both valid flags; payload registers are not reset.
// Both stages advance whenever the downstream stage is empty or being drained.
module narrow_float_quantizer (
  input  logic clk_i,
  input  logic rst_ni,
  nfq_stream_if.sink   in_i,
  nfq_stream_if.source out_o
);
  import nfq_pkg::*;

  in_item_t    in_d, in_q;
  logic        in_vld_q;
  out_item_t   res_d, res_q;
  logic        res_vld_q;
  logic        adv_res, adv_in;
  logic [7:0]  fp8_nb;
  logic [31:0] fp8_wb;
  logic [15:0] half_nb;
  logic [31:0] half_wb;
  logic [31:0] bf_sum;

  // Advance the result stage when empty or its transfer happens now.
  assign adv_res  = !res_vld_q || out_o.ready;
  assign adv_in   = !in_vld_q || adv_res;
  assign in_i.ready = adv_in;
  assign in_d     = in_item_t'(in_i.data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (adv_in) in_vld_q <= in_i.valid;
      if (adv_res) res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_i.valid) in_q <= in_d;
    if (adv_res && in_vld_q) res_q <= res_d;
  end

  nfq_fp8_conv u_fp8 (.value_i(in_q.value_bits), .narrow_o(fp8_nb), .widened_o(fp8_wb));
  nfq_half_conv u_half (.value_i(in_q.value_bits), .narrow_o(half_nb), .widened_o(half_wb));

  // Select the target format or pass-through; bfloat16 rounds to nearest even except Inf and NaN.
  always_comb begin
    bf_sum = in_q.value_bits + 32'h7FFF + {31'd0, in_q.value_bits[16]};
    unique case (action_e'(in_q.action))
      ACT_FP8: begin
        res_d.narrow_bits  = {8'd0, fp8_nb};
        res_d.widened_bits = fp8_wb;
      end
      ACT_HALF: begin
        res_d.narrow_bits  = half_nb;
        res_d.widened_bits = half_wb;
      end
      ACT_BF16: begin
        if ((in_q.value_bits & F32_EXP_MASK) == F32_EXP_MASK) begin
          res_d.widened_bits = {in_q.value_bits[31:17],
                                in_q.value_bits[16] | (in_q.value_bits[22:0] != 23'd0), 16'd0};
        end else begin
          res_d.widened_bits = {bf_sum[31:16], 16'd0};
        end
        res_d.narrow_bits = res_d.widened_bits[31:16];
      end
      default: begin
        res_d.narrow_bits  = 16'd0;
        res_d.widened_bits = in_q.value_bits;
      end
    endcase
  end

  assign out_o.valid = res_vld_q;
  assign out_o.data  = res_q;
endmodule
